[design/pidp_pkg.sv]
// ----------------------------------------------------------------------------
// pidp_pkg
// shared widths, register defaults and register indexes of the pwm id
// pattern detector
// ----------------------------------------------------------------------------
`default_nettype none

package pidp_pkg;

    localparam int REG_W      = 16;
    localparam int IDX_W      = 5;
    localparam int CFG_ADDR_W = 3;

    localparam int PATTERN_BITS_DEF = 16;

    localparam logic [REG_W-1:0] PATTERN_ID_RST    = 16'hCA3A;
    localparam logic [REG_W-1:0] PERIOD_MIN_RST    = 16'd900;
    localparam logic [REG_W-1:0] PERIOD_MAX_RST    = 16'd1100;
    localparam logic [REG_W-1:0] WIDTH_MIN_RST     = 16'd150;
    localparam logic [REG_W-1:0] WIDTH_SPLIT_RST   = 16'd350;
    localparam logic [REG_W-1:0] WIDTH_MAX_RST     = 16'd600;
    localparam logic [REG_W-1:0] TIMEOUT_TICKS_RST = 16'hFFFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_ID    = 3'd0,
        REG_PERIOD_MIN    = 3'd1,
        REG_PERIOD_MAX    = 3'd2,
        REG_WIDTH_MIN     = 3'd3,
        REG_WIDTH_SPLIT   = 3'd4,
        REG_WIDTH_MAX     = 3'd5,
        REG_TIMEOUT_TICKS = 3'd6
    } t_cfg_reg;

    // input command codes
    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

endpackage

`default_nettype wire

[design/pidp_in_if.sv]
// ----------------------------------------------------------------------------
// pidp_in_if
// input channel: measured pulse or timeout tick, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pidp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [pidp_pkg::REG_W-1:0]  period;
    logic [pidp_pkg::REG_W-1:0]  high_time;

    modport source (output valid, output cmd, output period, output high_time, input ready);
    modport sink   (input valid, input cmd, input period, input high_time, output ready);
endinterface

`default_nettype wire

[design/pidp_out_if.sv]
// ----------------------------------------------------------------------------
// pidp_out_if
// result channel: detect level and match status, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pidp_out_if;
    logic                        valid;
    logic                        ready;
    logic                        detect_level;
    logic                        match_done;
    logic                        timed_out;
    logic [pidp_pkg::IDX_W-1:0]  progress;

    modport source (output valid, output detect_level, output match_done,
                    output timed_out, output progress, input ready);
    modport sink   (input valid, input detect_level, input match_done,
                    input timed_out, input progress, output ready);
endinterface

`default_nettype wire

[design/pwm_id_pattern_detector.sv]
// ----------------------------------------------------------------------------
// pwm_id_pattern_detector
// classifies measured pwm pulses into bits, matches them against a 16 bit
// id lsb first and toggles a detect level on each full match
// ----------------------------------------------------------------------------
// path: an accepted input beat is held in the input register, and its result
//   in the result register; throughput: one beat per cycle while the result
//   channel is not stalled, set by the state update between the two registers
// reset: synchronous active low; registers return to their default values,
//   bit index and detect level clear, countdown loads 65535
`default_nettype none

module pwm_id_pattern_detector #(
    parameter int PATTERN_BITS = pidp_pkg::PATTERN_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    pidp_in_if.sink                           i_in,
    pidp_out_if.source                        o_out,
    input  wire                               i_cfg_we,
    input  wire [pidp_pkg::CFG_ADDR_W-1:0]    i_cfg_idx,
    input  wire [pidp_pkg::REG_W-1:0]         i_cfg_data
);

    localparam int W  = pidp_pkg::REG_W;
    localparam int IW = pidp_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_COUNT = IW'(PATTERN_BITS);

    // configuration registers
    logic [W-1:0] r_pattern_id;
    logic [W-1:0] r_period_min;
    logic [W-1:0] r_period_max;
    logic [W-1:0] r_width_min;
    logic [W-1:0] r_width_split;
    logic [W-1:0] r_width_max;
    logic [W-1:0] r_timeout_ticks;

    // detector state
    logic [IW-1:0] r_bit_idx;
    logic          r_level;
    logic [W-1:0]  r_cnt;

    // input register stage
    logic          r_in_vld;
    logic          r_in_cmd;
    logic [W-1:0]  r_in_period;
    logic [W-1:0]  r_in_high;

    // result register stage
    logic          r_out_vld;
    logic          r_out_level;
    logic          r_out_done;
    logic          r_out_expired;
    logic [IW-1:0] r_out_progress;

    // next state and result of the beat in the input register
    logic [IW-1:0] n_bit_idx;
    logic          n_level;
    logic [W-1:0]  n_cnt;
    logic          n_done;
    logic          n_expired;
    logic [IW-1:0] n_progress;

    logic          w_adv;
    logic          w_in_take;
    logic          w_in_window;
    logic          w_want;
    logic          w_hit;
    logic [IW-1:0] w_idx_inc;

    // input register moves on when the result register is free or draining
    assign w_adv     = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || w_adv;
    assign w_in_take = i_in.valid && i_in.ready;

    // ------------------------------------------------------------------
    // configuration writes; indexes past the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_id    <= pidp_pkg::PATTERN_ID_RST;
            r_period_min    <= pidp_pkg::PERIOD_MIN_RST;
            r_period_max    <= pidp_pkg::PERIOD_MAX_RST;
            r_width_min     <= pidp_pkg::WIDTH_MIN_RST;
            r_width_split   <= pidp_pkg::WIDTH_SPLIT_RST;
            r_width_max     <= pidp_pkg::WIDTH_MAX_RST;
            r_timeout_ticks <= pidp_pkg::TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pidp_pkg::REG_PATTERN_ID:    r_pattern_id    <= i_cfg_data;
                pidp_pkg::REG_PERIOD_MIN:    r_period_min    <= i_cfg_data;
                pidp_pkg::REG_PERIOD_MAX:    r_period_max    <= i_cfg_data;
                pidp_pkg::REG_WIDTH_MIN:     r_width_min     <= i_cfg_data;
                pidp_pkg::REG_WIDTH_SPLIT:   r_width_split   <= i_cfg_data;
                pidp_pkg::REG_WIDTH_MAX:     r_width_max     <= i_cfg_data;
                pidp_pkg::REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pulse classification and state update
    // ------------------------------------------------------------------
    assign w_in_window = (r_in_period >= r_period_min) && (r_in_period <= r_period_max) &&
                         (r_in_high >= r_width_min) && (r_in_high <= r_width_max);

    // expected bit, lsb first
    assign w_want    = r_pattern_id[r_bit_idx[3:0]];
    // a high time exactly at the split matches either bit
    assign w_hit     = w_want ? (r_in_high >= r_width_split) : (r_in_high <= r_width_split);
    assign w_idx_inc = r_bit_idx + IW'(1);

    always_comb begin
        n_bit_idx = r_bit_idx;
        n_level   = r_level;
        n_cnt     = r_cnt;
        n_done    = 1'b0;
        n_expired = 1'b0;
        if (r_in_cmd == pidp_pkg::CMD_TICK) begin
            if (r_cnt == '0) begin
                // countdown expired: drop the line and start over
                n_expired = 1'b1;
                n_level   = 1'b0;
                n_bit_idx = '0;
                n_cnt     = r_timeout_ticks;
            end else begin
                n_cnt = r_cnt - W'(1);
            end
        end else if (w_in_window) begin
            if (w_hit) begin
                if (w_idx_inc >= LAST_COUNT) begin
                    // full pattern seen
                    n_done    = 1'b1;
                    n_level   = !r_level;
                    n_bit_idx = '0;
                    n_cnt     = r_timeout_ticks;
                end else begin
                    n_bit_idx = w_idx_inc;
                end
            end else begin
                n_bit_idx = '0;
            end
        end
        n_progress = n_done ? LAST_COUNT : n_bit_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_idx <= '0;
            r_level   <= 1'b0;
            r_cnt     <= pidp_pkg::TIMEOUT_TICKS_RST;
        end else if (w_adv) begin
            r_bit_idx <= n_bit_idx;
            r_level   <= n_level;
            r_cnt     <= n_cnt;
        end
    end

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_cmd    <= i_in.cmd;
            r_in_period <= i_in.period;
            r_in_high   <= i_in.high_time;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_level    <= n_level;
            r_out_done     <= n_done;
            r_out_expired  <= n_expired;
            r_out_progress <= n_progress;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.detect_level = r_out_level;
    assign o_out.match_done   = r_out_done;
    assign o_out.timed_out    = r_out_expired;
    assign o_out.progress     = r_out_progress;

`ifndef NO_ASSERTIONS
    // bit index never reaches the pattern length between beats
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_idx < LAST_COUNT)
        else $error("bit index out of range");

    // a beat cannot both complete the pattern and expire the countdown
    a_done_xor_expire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_done && r_out_expired))
        else $error("match and timeout on one beat");

    // a completed pattern reports full progress
    a_done_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_done) |-> (r_out_progress == LAST_COUNT))
        else $error("match without full progress");

    // an expiry clears the line and the index
    a_expire_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_expired) |=> (!r_level && (r_bit_idx == '0)))
        else $error("timeout did not clear state");
`endif

endmodule

`default_nettype wire
